// File: rtl/lcsb_pkg.sv
// lcsb_pkg: shared widths, reset values and sizing constants for the lcs length unit
// no dependencies; used by lcsb_tally, lcs_length_of_bit_words_unit and the bench
`default_nettype none

package lcsb_pkg;

    localparam int WORD_W          = 32;
    localparam int LEN_REG_W       = 6;
    localparam int OUT_W           = 6;
    localparam int MAX_LEN_DEFAULT = 32;
    localparam int GRP_W           = 8;

    localparam logic [LEN_REG_W-1:0] STRING_LENGTH_RESET = 6'd32;

endpackage

`default_nettype wire

// File: rtl/lcsb_cell.sv
// lcsb_cell: one row of the bit-parallel lcs table, one x bit per cell
// uses no package items; instantiated in a chain by lcs_length_of_bit_words_unit
`default_nettype none

module lcsb_cell #(
    parameter int W     = 32,
    parameter int ROW   = 0,
    parameter int LEN_W = 6
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic [LEN_W-1:0] len,
    input  wire logic             in_valid,
    input  wire logic [W-1:0]     in_x,
    input  wire logic [W-1:0]     in_y,
    input  wire logic [W-1:0]     in_v,
    output logic                  out_valid,
    output logic [W-1:0]          out_x,
    output logic [W-1:0]          out_y,
    output logic [W-1:0]          out_v
);

    logic         valid_reg;
    logic [W-1:0] x_reg;
    logic [W-1:0] y_reg;
    logic [W-1:0] v_reg;
    logic [W-1:0] v_next;
    logic [W-1:0] match;
    logic         active;

    // match vector: columns whose y bit equals this row's x bit
    always_comb
    begin
        match  = ~(in_y ^ {W{in_x[ROW]}});
        active = LEN_W'(ROW) < len;
        if (active)
        begin
            v_next = (in_v + (in_v & match)) | (in_v & ~match);
        end
        else
        begin
            v_next = in_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= in_x;
            y_reg <= in_y;
            v_reg <= v_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_v     = v_reg;

endmodule

`default_nettype wire

// File: rtl/lcsb_tally.sv
// lcsb_tally: two-stage count of zero bits of the final row vector inside the length mask
// depends on lcsb_pkg (group width)
`default_nettype none

module lcsb_tally #(
    parameter int W     = 32,
    parameter int CNT_W = 6
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [W-1:0]     in_v,
    input  wire logic [W-1:0]     mask,
    output logic                  out_valid,
    output logic [CNT_W-1:0]      out_count
);

    localparam int GRP_W  = lcsb_pkg::GRP_W;
    localparam int NGRP   = (W + GRP_W - 1) / GRP_W;
    localparam int PAD_W  = NGRP * GRP_W;
    localparam int GCNT_W = $clog2(GRP_W + 1);

    logic [PAD_W-1:0]  zero_bits;
    logic [GCNT_W-1:0] grp_next [NGRP];
    logic [GCNT_W-1:0] grp_reg  [NGRP];
    logic [CNT_W-1:0]  sum_next;
    logic [CNT_W-1:0]  sum_reg;
    logic              grp_valid_reg;
    logic              sum_valid_reg;

    // per-group counts of zero bits
    always_comb
    begin
        zero_bits = PAD_W'(~in_v & mask);
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int b = 0; b < GRP_W; b++)
            begin
                grp_next[g] = grp_next[g] + GCNT_W'(zero_bits[g*GRP_W + b]);
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            sum_next = sum_next + CNT_W'(grp_reg[g]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            grp_valid_reg <= in_valid;
            sum_valid_reg <= grp_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            grp_reg <= grp_next;
            sum_reg <= sum_next;
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_count = sum_reg;

endmodule

`default_nettype wire

// File: rtl/lcs_length_of_bit_words_unit.sv
// lcs_length_of_bit_words_unit: top level, chain of row cells, zero tally and output skid
// depends on lcsb_pkg, lcsb_cell and lcsb_tally
//
// usage
//   s_tdata carries a request: x_word in [31:0], y_word in [63:32]. m_tdata carries
//   subseq_len in [5:0], upper bits zero. cfg_data writes string_length (the number of
//   low bits of each word that form the strings); cfg_ready is always high. write it
//   only while no request is in flight.
//   the pair runs through MAX_LEN row cells, one per cycle unless the chain is frozen,
//   each applying one x bit to a MAX_LEN-bit column vector with one add; a two-stage
//   tally then counts zero bits. an accepted request passes the cell registers, the two
//   tally registers and the output register before m_tvalid. throughput: one request per
//   cycle while the skid register is empty, set by the cell chain.
//   reset clears all valid flags and sets string_length to 32; no result is pending.
//   when the receiver stalls, one result waits in the output register and a second in
//   a skid register; while the skid register is full the chain freezes and s_tready
//   is low. s_tready comes from a register.
`default_nettype none

module lcs_length_of_bit_words_unit #(
    parameter int MAX_LEN = lcsb_pkg::MAX_LEN_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // cfg_data: string_length
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [lcsb_pkg::LEN_REG_W-1:0]  cfg_data,
    // s_tdata: x_word [31:0], y_word [63:32]
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [2*lcsb_pkg::WORD_W-1:0]   s_tdata,
    // m_tdata: subseq_len [5:0], zero fill [7:6]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [7:0]                           m_tdata
);

    localparam int WORD_W = lcsb_pkg::WORD_W;
    localparam int OUT_W  = lcsb_pkg::OUT_W;
    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int CNT_W  = $clog2(MAX_LEN + 1);

    logic [lcsb_pkg::LEN_REG_W-1:0] string_length_reg;
    logic [LEN_W-1:0]               len_eff;
    logic [MAX_LEN-1:0]             len_mask;

    logic [MAX_LEN-1:0] x_ext;
    logic [MAX_LEN-1:0] y_ext;

    logic               en;
    logic [MAX_LEN:0]   valid_chain;
    logic [MAX_LEN-1:0] x_chain [MAX_LEN+1];
    logic [MAX_LEN-1:0] y_chain [MAX_LEN+1];
    logic [MAX_LEN-1:0] v_chain [MAX_LEN+1];

    logic               tally_valid;
    logic [CNT_W-1:0]   tally_count;
    logic [OUT_W-1:0]   result;

    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;
    logic               skid_valid_reg;
    logic [OUT_W-1:0]   skid_data_reg;
    logic               out_take;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            string_length_reg <= lcsb_pkg::STRING_LENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            string_length_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (int'(string_length_reg) > MAX_LEN)
        begin
            len_eff = LEN_W'(MAX_LEN);
        end
        else
        begin
            len_eff = LEN_W'(string_length_reg);
        end
        for (int k = 0; k < MAX_LEN; k++)
        begin
            len_mask[k] = LEN_W'(k) < len_eff;
        end
    end

    // words padded with zeros above bit 31, or cut to MAX_LEN bits
    generate
        if (MAX_LEN > WORD_W)
        begin : g_pad
            assign x_ext = {{(MAX_LEN-WORD_W){1'b0}}, s_tdata[WORD_W-1:0]};
            assign y_ext = {{(MAX_LEN-WORD_W){1'b0}}, s_tdata[2*WORD_W-1:WORD_W]};
        end
        else
        begin : g_cut
            assign x_ext = s_tdata[MAX_LEN-1:0];
            assign y_ext = s_tdata[WORD_W+MAX_LEN-1:WORD_W];
        end
    endgenerate

    // cell chain
    assign en             = !skid_valid_reg;
    assign s_tready       = en;
    assign valid_chain[0] = s_tvalid;
    assign x_chain[0]     = x_ext;
    assign y_chain[0]     = y_ext;
    assign v_chain[0]     = '1;

    generate
        for (genvar r = 0; r < MAX_LEN; r++)
        begin : g_row
            lcsb_cell #(
                .W     (MAX_LEN),
                .ROW   (r),
                .LEN_W (LEN_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .len       (len_eff),
                .in_valid  (valid_chain[r]),
                .in_x      (x_chain[r]),
                .in_y      (y_chain[r]),
                .in_v      (v_chain[r]),
                .out_valid (valid_chain[r+1]),
                .out_x     (x_chain[r+1]),
                .out_y     (y_chain[r+1]),
                .out_v     (v_chain[r+1])
            );
        end
    endgenerate

    lcsb_tally #(
        .W     (MAX_LEN),
        .CNT_W (CNT_W)
    ) u_tally (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (valid_chain[MAX_LEN]),
        .in_v      (v_chain[MAX_LEN]),
        .mask      (len_mask),
        .out_valid (tally_valid),
        .out_count (tally_count)
    );

    assign result = OUT_W'(tally_count);

    // output register and skid
    assign out_take = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (tally_valid)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (tally_valid)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_data_reg <= result;
            end
            else
            begin
                out_data_reg <= result;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 8'(out_data_reg);

    // checks
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output register is empty");

    a_chain_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> $stable(valid_chain[MAX_LEN:1]) && $stable(tally_valid))
        else $error("cell chain moved while skid register was full");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (tally_valid && !skid_valid_reg && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("finished result not captured during output stall");

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// tb_top: self-checking bench for lcs_length_of_bit_words_unit, bit-string lcs length
// depends on lcsb_pkg and the unit; scoreboard predicts every request at the port widths
// directed corner cases, random traffic under several idle mixes, and a long output stall
module tb_top;

    localparam int WORD_W      = lcsb_pkg::WORD_W;
    localparam int OUT_W       = lcsb_pkg::OUT_W;
    localparam int LEN_REG_W   = lcsb_pkg::LEN_REG_W;
    localparam int MAX_LEN     = lcsb_pkg::MAX_LEN_DEFAULT;
    localparam int LATENCY     = MAX_LEN + 3;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int SHOWN_ERRS  = 10;

    typedef logic [OUT_W-1:0]     lcs_t;
    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [LEN_REG_W-1:0] len_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    len_t                  cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [2*WORD_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;

    lcs_t        lcs_q[$];
    len_t        string_len;
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    logic        hold_sink;
    int          errors;
    int          quiet;

    lcs_length_of_bit_words_unit #(
        .MAX_LEN (MAX_LEN)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // dp table over the low bits, msb of the used range first
    function automatic lcs_t lcs_of_words(input word_t xw, input word_t yw, input len_t len_reg);
        int unsigned n;
        int unsigned i;
        int unsigned j;
        int unsigned prev [MAX_LEN+1];
        int unsigned cur [MAX_LEN+1];
        logic        xb;
        logic        yb;
        n = (len_reg > MAX_LEN) ? MAX_LEN : len_reg;
        for (j = 0; j <= MAX_LEN; j++)
        begin
            prev[j] = 0;
            cur[j]  = 0;
        end
        for (i = 1; i <= n; i++)
        begin
            xb = (n - i < WORD_W) ? xw[n-i] : 1'b0;
            cur[0] = 0;
            for (j = 1; j <= n; j++)
            begin
                yb = (n - j < WORD_W) ? yw[n-j] : 1'b0;
                if (xb == yb)
                    cur[j] = prev[j-1] + 1;
                else
                    cur[j] = (cur[j-1] > prev[j]) ? cur[j-1] : prev[j];
            end
            for (j = 0; j <= n; j++)
                prev[j] = cur[j];
        end
        return lcs_t'(prev[n]);
    endfunction

    function automatic void note_mismatch(input string what, input logic [7:0] want,
                                          input logic [7:0] got);
        errors++;
        if (errors <= SHOWN_ERRS)
            $display("mismatch (%s): expected subseq_len %0d, got m_tdata 0x%02h",
                     what, want, got);
    endfunction

    // sender: idles at random, keeps tvalid high across back-to-back requests
    task automatic send_pair(input word_t xw, input word_t yw);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {yw, xw};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        lcs_q.push_back(lcs_of_words(xw, yw, string_len));
    endtask

    task automatic write_string_length(input len_t value);
        s_tvalid <= 1'b0;
        while (lcs_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        string_len = value;
    endtask

    task automatic rand_pair(output word_t xw, output word_t yw);
        xw = $urandom;
        case ($urandom_range(4))
            0: yw = $urandom;
            1:
            begin
                xw = $urandom & $urandom & $urandom;
                yw = $urandom & $urandom & $urandom;
            end
            2:
            begin
                xw = $urandom | $urandom | $urandom;
                yw = $urandom | $urandom;
            end
            3: yw = xw ^ (word_t'(1) << $urandom_range(WORD_W-1));
            default: yw = {xw[WORD_W-2:0], xw[WORD_W-1]};
        endcase
    endtask

    function automatic len_t pick_length();
        case ($urandom_range(7))
            0: return len_t'(1);
            1: return len_t'(32);
            2: return len_t'(33);
            3: return len_t'(63);
            4: return len_t'(0);
            default: return len_t'($urandom_range(2, 31));
        endcase
    endfunction

    task automatic test_reset_length;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_pair(32'h0000_0000, 32'h0000_0000);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'hFFFF_FFFF, 32'h0000_0000);
        send_pair(32'hAAAA_AAAA, 32'h5555_5555);
        send_pair(32'hFFFF_0000, 32'h0000_FFFF);
        send_pair(32'h8000_0000, 32'h0000_0001);
        send_pair(32'h1234_5678, 32'h1234_5678);
    endtask

    task automatic test_length_extremes;
        // zero length gives empty strings
        write_string_length(len_t'(0));
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'h0000_0000, 32'h0000_0000);
        write_string_length(len_t'(1));
        send_pair(32'h0000_0001, 32'h0000_0001);
        send_pair(32'hFFFF_FFFE, 32'h0000_0001);
        // lengths above the table size saturate
        write_string_length(len_t'(33));
        send_pair(32'h0000_0000, 32'h0000_0000);
        send_pair(32'hFFFF_FFFF, 32'h0000_0000);
        write_string_length(len_t'(63));
        send_pair(32'hAAAA_AAAA, 32'hAAAA_AAAA);
        send_pair(32'hF0F0_F0F0, 32'h0F0F_0F0F);
        // bits above the length are ignored
        write_string_length(len_t'(4));
        send_pair(32'hFFFF_FFF0, 32'h0000_000F);
        send_pair(32'h0000_0005, 32'hFFFF_FFFA);
        send_pair(32'hDEAD_BEE9, 32'h0000_0009);
    endtask

    task automatic test_random_traffic;
        word_t xw;
        word_t yw;
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 50;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 50;
                end
                default:
                begin
                    src_idle_pct   = 31;
                    sink_stall_pct = 31;
                end
            endcase
            for (int s = 0; s < 4; s++)
            begin
                write_string_length(pick_length());
                for (int k = 0; k < 90; k++)
                begin
                    rand_pair(xw, yw);
                    send_pair(xw, yw);
                end
            end
        end
    endtask

    // receiver holds off long enough for the chain to fill and drop s_tready
    task automatic test_output_backpressure;
        word_t xw;
        word_t yw;
        write_string_length(len_t'(32));
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_sink <= 1'b1;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_sink <= 1'b0;
            end
            for (int k = 0; k < 100; k++)
            begin
                rand_pair(xw, yw);
                send_pair(xw, yw);
            end
        join
    endtask

    always @(posedge clk)
        m_tready <= !hold_sink && ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (lcs_q.size() == 0)
                note_mismatch("no request pending", 8'h00, m_tdata);
            else if (m_tdata !== {2'b00, lcs_q[0]})
                note_mismatch("subseq_len", {2'b00, lcs_q.pop_front()}, m_tdata);
            else
                void'(lcs_q.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        hold_sink      = 1'b0;
        errors         = 0;
        quiet          = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        string_len     = lcsb_pkg::STRING_LENGTH_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_length();
        test_length_extremes();
        test_random_traffic();
        test_output_backpressure();

        s_tvalid <= 1'b0;
        while (lcs_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
        if (errors == 0 && lcs_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
